[rtl/core/token_dictionary_substitution_defines.svh]
// assertion macros used by the checker file tds_checker
`ifndef TOKEN_DICTIONARY_SUBSTITUTION_DEFINES_SVH
`define TOKEN_DICTIONARY_SUBSTITUTION_DEFINES_SVH

// same-cycle implication, quiet while reset is high
`define TDS_ASSERT_NOW(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("tds assertion failed");

// next-cycle implication, quiet while reset is high
`define TDS_ASSERT_NEXT(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("tds assertion failed");

// property that must hold in the cycle after reset
`define TDS_ASSERT_RST(name, cons) \
  name: assert property (@(posedge clk) rst |=> (cons)) \
    else $error("tds reset assertion failed");

`endif

[rtl/core/tds_pkg.sv]
// ----------------------------------------------------------------------------
// tds_pkg
// Constants, codes and helper functions of the token substitution block.
// ----------------------------------------------------------------------------
package tds_pkg;

  localparam int NUM_ENTRIES = 16;
  localparam int MAX_LEN     = 32;

  localparam int PAIR_W = $clog2(NUM_ENTRIES);
  localparam int LEN_W  = $clog2(MAX_LEN);
  localparam int CNT_W  = $clog2(NUM_ENTRIES + 1);
  localparam int ADDR_W = PAIR_W + LEN_W;
  localparam int STORE_DEPTH = NUM_ENTRIES * MAX_LEN;
  localparam int WORD_DEPTH  = MAX_LEN - 1;

  typedef enum logic [1:0] {
    FUNC_PAT  = 2'd0,
    FUNC_REPL = 2'd1,
    FUNC_TEXT = 2'd2,
    FUNC_END  = 2'd3
  } func_t;

  typedef enum logic [1:0] {
    MODE_IDENT = 2'd0,
    MODE_DOT   = 2'd1,
    MODE_ARITH = 2'd2,
    MODE_SPARE = 2'd3
  } mode_t;

  localparam logic [0:0] REG_MODE  = 1'b0;
  localparam logic [0:0] REG_PAIRS = 1'b1;

  function automatic logic in_class(input logic [1:0] mode, input logic [7:0] b);
    logic digit;
    logic alpha;
    logic res;
    digit = (b >= "0") && (b <= "9");
    alpha = ((b >= "a") && (b <= "z")) || ((b >= "A") && (b <= "Z"));
    case (mode)
      MODE_ARITH: res = digit || (b == "+") || (b == "-") || (b == "*") || (b == "/");
      MODE_DOT:   res = alpha || digit || (b == "_") || (b == ".");
      default:    res = alpha || digit || (b == "_");
    endcase
    return res;
  endfunction

endpackage

[rtl/core/token_dictionary_substitution.sv]
// Load and word bytes are taken only while idle with the output not stalled.
// A delimiter or end of text starts a pattern search (a registered RAM read,
// then a compare, per compared byte per pattern); a matched replacement is
// read to size it; each output byte is read, then emitted; any delimiter last.
// Reset clears mode, pair_count, word length and error hold; the RAMs keep
// their contents and need no clearing pass.
// ----------------------------------------------------------------------------
// token_dictionary_substitution
// Groups text bytes into words and replaces words found in a pattern table.
// ----------------------------------------------------------------------------
module token_dictionary_substitution
  import tds_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_we,
  input  logic [0:0] cfg_index,
  input  logic [4:0] cfg_data,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [1:0] func,
  input  logic [3:0] entry,
  input  logic [4:0] position,
  input  logic [7:0] data_byte,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_byte,
  output logic       replaced,
  output logic       status,
  output logic       last
);

  typedef enum logic [7:0] {
    ST_IDLE  = 8'b00000001,
    ST_S_RD  = 8'b00000010,
    ST_S_CMP = 8'b00000100,
    ST_L_RD  = 8'b00001000,
    ST_L_CMP = 8'b00010000,
    ST_E_RD  = 8'b00100000,
    ST_E_OUT = 8'b01000000,
    ST_D_OUT = 8'b10000000
  } state_t;

  state_t             state;
  logic [1:0]         mode;
  logic [4:0]         pair_count;
  logic [LEN_W-1:0]   word_length;
  logic               error_hold;
  logic [CNT_W-1:0]   pat;
  logic [LEN_W-1:0]   idx;
  logic [LEN_W-1:0]   cnt;
  logic               matched;
  logic [PAIR_W-1:0]  match_idx;
  logic               has_delim;
  logic [7:0]         delim;

  logic [CNT_W-1:0]   npairs;
  logic               acc;
  logic               slot_free;
  logic               is_class;
  logic               too_long;
  logic               out_load;
  logic [7:0]         pat_rdata;
  logic [7:0]         repl_rdata;
  logic [7:0]         word_rdata;
  logic [7:0]         emit_data;
  logic               pat_we;
  logic               repl_we;
  logic               word_we;
  logic               pat_re;
  logic               repl_re;
  logic               word_re;
  logic [ADDR_W-1:0]  load_addr;
  logic [ADDR_W-1:0]  repl_raddr;

  assign npairs = (pair_count > 5'(NUM_ENTRIES)) ? CNT_W'(NUM_ENTRIES) : CNT_W'(pair_count);
  assign slot_free = !out_valid || !out_stall;
  assign in_stall  = (state != ST_IDLE) || (out_valid && out_stall);
  assign acc       = in_valid && !in_stall;
  assign is_class  = in_class(mode, data_byte);
  assign too_long  = word_length >= LEN_W'(MAX_LEN - 2);

  // a new result enters the output register this cycle
  assign out_load = (state == ST_IDLE) ?
                    (acc && (func == FUNC_TEXT) && !error_hold && is_class && too_long) :
                    (((state == ST_E_OUT) || (state == ST_D_OUT)) && slot_free);

  assign load_addr = {entry[PAIR_W-1:0], position[LEN_W-1:0]};
  assign pat_we  = acc && (func == FUNC_PAT);
  assign repl_we = acc && (func == FUNC_REPL);
  assign word_we = acc && (func == FUNC_TEXT) && !error_hold && is_class && !too_long;

  assign pat_re  = (state == ST_S_RD) && (pat != npairs);
  assign word_re = pat_re || ((state == ST_E_RD) && !matched);
  assign repl_re = (state == ST_L_RD) || ((state == ST_E_RD) && matched);
  assign repl_raddr = {match_idx, idx};
  assign emit_data  = matched ? repl_rdata : word_rdata;

  tds_ram #(.DEPTH(STORE_DEPTH), .WIDTH(8)) u_pat_ram (
    .clk   (clk),
    .we    (pat_we),
    .waddr (load_addr),
    .wdata (data_byte),
    .re    (pat_re),
    .raddr ({pat[PAIR_W-1:0], idx}),
    .rdata (pat_rdata)
  );

  tds_ram #(.DEPTH(STORE_DEPTH), .WIDTH(8)) u_repl_ram (
    .clk   (clk),
    .we    (repl_we),
    .waddr (load_addr),
    .wdata (data_byte),
    .re    (repl_re),
    .raddr (repl_raddr),
    .rdata (repl_rdata)
  );

  tds_ram #(.DEPTH(WORD_DEPTH), .WIDTH(8)) u_word_ram (
    .clk   (clk),
    .we    (word_we),
    .waddr (word_length),
    .wdata (data_byte),
    .re    (word_re),
    .raddr (idx),
    .rdata (word_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      mode        <= '0;
      pair_count  <= '0;
      word_length <= '0;
      error_hold  <= 1'b0;
      out_valid   <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          REG_MODE:  mode <= cfg_data[1:0];
          REG_PAIRS: pair_count <= cfg_data;
          default:   ;
        endcase
      end

      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end

      unique case (state)
        ST_IDLE: begin
          if (acc && (func == FUNC_TEXT) && !error_hold) begin
            if (is_class) begin
              if (too_long) begin
                error_hold  <= 1'b1;
                word_length <= '0;
                out_byte    <= '0;
                replaced    <= 1'b0;
                status      <= 1'b1;
                last        <= 1'b1;
              end else begin
                word_length <= word_length + 1'b1;
              end
            end else begin
              has_delim <= 1'b1;
              delim     <= data_byte;
              pat       <= '0;
              idx       <= '0;
              state     <= ST_S_RD;
            end
          end else if (acc && (func == FUNC_END)) begin
            error_hold <= 1'b0;
            if (!error_hold && (word_length != '0)) begin
              has_delim <= 1'b0;
              pat       <= '0;
              idx       <= '0;
              state     <= ST_S_RD;
            end else begin
              word_length <= '0;
            end
          end
        end
        ST_S_RD: begin
          if (pat == npairs) begin
            // no pattern matched, emit the word itself
            matched <= 1'b0;
            cnt     <= word_length;
            idx     <= '0;
            if (word_length == '0) begin
              state <= has_delim ? ST_D_OUT : ST_IDLE;
            end else begin
              state <= ST_E_RD;
            end
          end else begin
            state <= ST_S_CMP;
          end
        end
        ST_S_CMP: begin
          if (idx == word_length) begin
            // pattern must end exactly where the word ends
            if (pat_rdata == '0) begin
              matched   <= 1'b1;
              match_idx <= pat[PAIR_W-1:0];
              idx       <= '0;
              state     <= ST_L_RD;
            end else begin
              pat   <= pat + 1'b1;
              idx   <= '0;
              state <= ST_S_RD;
            end
          end else if (pat_rdata != word_rdata) begin
            pat   <= pat + 1'b1;
            idx   <= '0;
            state <= ST_S_RD;
          end else begin
            idx   <= idx + 1'b1;
            state <= ST_S_RD;
          end
        end
        ST_L_RD: begin
          state <= ST_L_CMP;
        end
        ST_L_CMP: begin
          if ((repl_rdata == '0) || (idx == LEN_W'(MAX_LEN - 2))) begin
            cnt <= (repl_rdata == '0) ? idx : LEN_W'(MAX_LEN - 1);
            idx <= '0;
            if (repl_rdata == '0 && idx == '0) begin
              if (has_delim) begin
                state <= ST_D_OUT;
              end else begin
                word_length <= '0;
                state       <= ST_IDLE;
              end
            end else begin
              state <= ST_E_RD;
            end
          end else begin
            idx   <= idx + 1'b1;
            state <= ST_L_RD;
          end
        end
        ST_E_RD: begin
          state <= ST_E_OUT;
        end
        ST_E_OUT: begin
          if (slot_free) begin
            out_byte  <= emit_data;
            replaced  <= matched;
            status    <= 1'b0;
            last      <= !has_delim && (idx == cnt - 1'b1);
            if (idx == cnt - 1'b1) begin
              if (has_delim) begin
                state <= ST_D_OUT;
              end else begin
                word_length <= '0;
                state       <= ST_IDLE;
              end
            end else begin
              idx   <= idx + 1'b1;
              state <= ST_E_RD;
            end
          end
        end
        ST_D_OUT: begin
          if (slot_free) begin
            out_byte    <= delim;
            replaced    <= 1'b0;
            status      <= 1'b0;
            last        <= 1'b1;
            word_length <= '0;
            state       <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

[rtl/core/tds_ram.sv]
// ----------------------------------------------------------------------------
// tds_ram
// Simple dual-port synchronous RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module tds_ram #(
  parameter int DEPTH = 512,
  parameter int WIDTH = 8
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // read data holds while re is low
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[rtl/core/tds_checker.sv]
// ----------------------------------------------------------------------------
// tds_checker
// Port-level checks of the token substitution block, bound to the top level.
// ----------------------------------------------------------------------------
`include "token_dictionary_substitution_defines.svh"

module tds_checker
  import tds_pkg::*;
(
  input logic       clk,
  input logic       rst,
  input logic       out_valid,
  input logic       out_stall,
  input logic [7:0] out_byte,
  input logic       replaced,
  input logic       status,
  input logic       last
);

  // a stalled result transfer holds its byte and its last flag
  `TDS_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_byte) && $stable(last))

  // an error result stands alone and carries no character
  `TDS_ASSERT_NOW(a_err_shape, out_valid && status, last && !replaced && (out_byte == '0))

  // a replacement character never reports an error
  `TDS_ASSERT_NOW(a_repl_ok, out_valid && replaced, !status)

  `TDS_ASSERT_RST(a_rst_idle, !out_valid)

endmodule

bind token_dictionary_substitution tds_checker u_tds_checker (
  .clk       (clk),
  .rst       (rst),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_byte  (out_byte),
  .replaced  (replaced),
  .status    (status),
  .last      (last)
);
